### hdl/bda_pkg.sv
// Shared types, constants and the breakpoint ROM of the backlight to dim-alpha block.
// Used by bda_div and backlight_to_dim_alpha_core. No other dependencies.
package bda_pkg;

   // Field widths.
   localparam int LVL_W   = 12;   // backlight level
   localparam int ALPHA_W = 8;    // alpha values and the override register
   localparam int BPL_W   = 10;   // breakpoint levels (up to 1023)

   // Breakpoint ROM.
   localparam int ROM_SIZE        = 20;
   localparam int TABLE_ENTRIES   = 20;
   localparam int LOW_LEVEL_LIMIT = 3;
   localparam int NUM_USED = (TABLE_ENTRIES > ROM_SIZE) ? ROM_SIZE :
                             ((TABLE_ENTRIES < 1) ? 1 : TABLE_ENTRIES);
   localparam int IDX_W = $clog2(ROM_SIZE + 1);

   localparam logic [BPL_W-1:0] BP_LEVEL [ROM_SIZE] = '{
      10'd0,   10'd1,   10'd2,   10'd3,   10'd4,   10'd6,   10'd10,  10'd20,
      10'd30,  10'd45,  10'd70,  10'd100, 10'd150, 10'd227, 10'd300, 10'd400,
      10'd500, 10'd600, 10'd800, 10'd1023
   };

   localparam logic [ALPHA_W-1:0] BP_ALPHA [ROM_SIZE] = '{
      8'hff, 8'hee, 8'he8, 8'he6, 8'he5, 8'he4, 8'he0, 8'hd5, 8'hce, 8'hc6,
      8'hb7, 8'had, 8'ha0, 8'h8a, 8'h80, 8'h6e, 8'h5b, 8'h50, 8'h38, 8'h18
   };

   // Divider widths: dividends stay below 2^20, divisors below 2^10.
   localparam int DIVD_W = 20;
   localparam int DSR_W  = 10;
   localparam int DCNT_W = $clog2(DIVD_W);

   // Signed widths of the interpolation terms.
   localparam int LINH_W = 10;
   localparam int CORR_W = 11;
   localparam int SUM_W  = 12;

   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [DSR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [DIVD_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_MUL_LIN,
      S_DIV_LIN,
      S_DIV_Q1,
      S_DIV_CORR,
      S_SUM,
      S_DONE
   } state_type;

   // ROM reads; an index past the ROM reads as zero.
   function automatic logic [BPL_W-1:0] rom_level(input logic [IDX_W-1:0] idx);
      logic [BPL_W-1:0] val;
      val = '0;
      if (idx < IDX_W'(ROM_SIZE)) begin
         val = BP_LEVEL[idx];
      end
      return val;
   endfunction

   function automatic logic [ALPHA_W-1:0] rom_alpha(input logic [IDX_W-1:0] idx);
      logic [ALPHA_W-1:0] val;
      val = '0;
      if (idx < IDX_W'(ROM_SIZE)) begin
         val = BP_ALPHA[idx];
      end
      return val;
   endfunction

endpackage

### hdl/backlight_to_dim_alpha_core.sv
// Top level of the backlight to dim-alpha block: sequencer, breakpoint scan and datapath.
// Depends on bda_pkg and instantiates bda_div (the shared divider).
//
//  channel | ports                                      | direction | handshake
//  --------+--------------------------------------------+-----------+-----------------------
//  request | req_backlight_level, req_hbm_active        | in        | req_valid / req_stall
//  result  | rsp_layer_alpha                            | out       | rsp_valid / rsp_stall
//  config  | csr_wr_data (alpha_override)               | in        | csr_wr_en, no wait
//
// A request that needs no interpolation (flag clear, override set, or level of 3 or less)
// goes straight from idle to the finish state. An interpolated request runs a breakpoint
// scan of one ROM entry per cycle, followed by three passes through the shared 20-bit
// restoring divider (only one pass when both alphas of the segment are equal). A level
// above the last breakpoint takes only the scan. Reset is synchronous; it clears the
// override, the saved alpha and all control state. A stalled result waits in the output
// register, and the next request is already taken meanwhile.
module backlight_to_dim_alpha_core (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [bda_pkg::LVL_W-1:0]   req_backlight_level,
   input  logic                        req_hbm_active,

   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [bda_pkg::ALPHA_W-1:0] rsp_layer_alpha,

   input  logic                        csr_wr_en,
   input  logic [bda_pkg::ALPHA_W-1:0] csr_wr_data
);

   // Control state.
   bda_pkg::state_type                 state_ff, state_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [bda_pkg::ALPHA_W-1:0]        override_ff, override_in;
   logic [bda_pkg::ALPHA_W-1:0]        saved_ff, saved_in;

   // Payload registers.
   logic [bda_pkg::ALPHA_W-1:0]        rsp_alpha_ff, rsp_alpha_in;
   logic [bda_pkg::LVL_W-1:0]          level_ff, level_in;
   logic [bda_pkg::IDX_W-1:0]          idx_ff, idx_in;
   logic [bda_pkg::BPL_W-1:0]          xa_ff, xa_in;
   logic [bda_pkg::BPL_W-1:0]          xb_ff, xb_in;
   logic [bda_pkg::ALPHA_W-1:0]        ya_ff, ya_in;
   logic [bda_pkg::ALPHA_W-1:0]        yb_ff, yb_in;
   logic signed [bda_pkg::LINH_W-1:0]  linh_ff, linh_in;
   logic signed [bda_pkg::CORR_W-1:0]  corr_ff, corr_in;
   logic [bda_pkg::ALPHA_W-1:0]        result_ff, result_in;

   // Datapath terms.
   logic                               accept;
   logic [bda_pkg::BPL_W-1:0]          t_off;      // level minus the lower breakpoint
   logic [bda_pkg::BPL_W-1:0]          s_off;      // upper breakpoint minus the level
   logic [bda_pkg::BPL_W-1:0]          dx;
   logic                               dy_neg;
   logic                               dy_zero;
   logic [bda_pkg::ALPHA_W-1:0]        dy_mag;
   logic [bda_pkg::BPL_W-1:0]          mul_a, mul_b;
   logic [2*bda_pkg::BPL_W-1:0]        product;
   logic [bda_pkg::LINH_W-1:0]         half_mag;
   logic signed [bda_pkg::SUM_W-1:0]   sum;
   logic [bda_pkg::BPL_W-1:0]          scan_level;

   bda_pkg::div_req_type               div_req;
   bda_pkg::div_rsp_type               div_rsp;

   bda_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_stall       = (state_ff != bda_pkg::S_IDLE);
   assign accept          = req_valid && !req_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_layer_alpha = rsp_alpha_ff;

   // Segment geometry. The scan guarantees xa < level <= xb, so all three stay in range.
   assign t_off   = level_ff[bda_pkg::BPL_W-1:0] - xa_ff;
   assign s_off   = xb_ff - level_ff[bda_pkg::BPL_W-1:0];
   assign dx      = xb_ff - xa_ff;
   assign dy_neg  = (yb_ff < ya_ff);
   assign dy_zero = (yb_ff == ya_ff);
   assign dy_mag  = dy_neg ? (ya_ff - yb_ff) : (yb_ff - ya_ff);

   // The single multiplier feeds the divider, which registers it on launch.
   assign product = mul_a * mul_b;

   // Rounding of the linear term: lin/2 + lin%2 with truncation is the magnitude
   // rounded up, carrying the sign of the alpha step.
   assign half_mag = {1'b0, div_rsp.quotient[bda_pkg::LINH_W-1:1]}
                   + {{(bda_pkg::LINH_W-1){1'b0}}, div_rsp.quotient[0]};

   // Final sum of the segment start, the rounded linear term and the correction.
   assign sum = $signed({{(bda_pkg::SUM_W-bda_pkg::ALPHA_W){1'b0}}, ya_ff})
              + $signed({{(bda_pkg::SUM_W-bda_pkg::LINH_W){linh_ff[bda_pkg::LINH_W-1]}},
                         linh_ff})
              + $signed({{(bda_pkg::SUM_W-bda_pkg::CORR_W){corr_ff[bda_pkg::CORR_W-1]}},
                         corr_ff});

   assign scan_level = bda_pkg::rom_level(idx_ff);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      override_in  = override_ff;
      saved_in     = saved_ff;
      rsp_alpha_in = rsp_alpha_ff;
      level_in     = level_ff;
      idx_in       = idx_ff;
      xa_in        = xa_ff;
      xb_in        = xb_ff;
      ya_in        = ya_ff;
      yb_in        = yb_ff;
      linh_in      = linh_ff;
      corr_in      = corr_ff;
      result_in    = result_ff;

      mul_a            = t_off;
      mul_b            = s_off;
      div_req.start    = 1'b0;
      div_req.dividend = {product[2*bda_pkg::BPL_W-2:0], 1'b0};
      div_req.divisor  = dx;

      if (csr_wr_en) begin
         override_in = csr_wr_data;
      end

      // The output register drains independently of the sequencer.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         bda_pkg::S_IDLE: begin
            if (accept) begin
               level_in = req_backlight_level;
               idx_in   = '0;
               if (!req_hbm_active) begin
                  result_in = '0;
                  state_in  = bda_pkg::S_DONE;
               end else if (override_ff != '0) begin
                  result_in = override_ff;
                  state_in  = bda_pkg::S_DONE;
               end else if (req_backlight_level <=
                            bda_pkg::LVL_W'(bda_pkg::LOW_LEVEL_LIMIT)) begin
                  result_in = saved_ff;
                  state_in  = bda_pkg::S_DONE;
               end else begin
                  state_in  = bda_pkg::S_SCAN;
               end
            end
         end

         bda_pkg::S_SCAN: begin
            // One ROM entry per cycle, looking for the first breakpoint at or above
            // the level.
            if (idx_ff == bda_pkg::IDX_W'(bda_pkg::NUM_USED)) begin
               // Above the last breakpoint in use: clamp to its alpha.
               result_in = bda_pkg::rom_alpha(bda_pkg::IDX_W'(bda_pkg::NUM_USED - 1));
               saved_in  = result_in;
               state_in  = bda_pkg::S_DONE;
            end else if ({{(bda_pkg::LVL_W-bda_pkg::BPL_W){1'b0}}, scan_level}
                         >= level_ff) begin
               if (idx_ff == '0) begin
                  result_in = bda_pkg::rom_alpha('0);
                  saved_in  = result_in;
                  state_in  = bda_pkg::S_DONE;
               end else begin
                  xa_in    = bda_pkg::rom_level(idx_ff - 1'b1);
                  xb_in    = scan_level;
                  ya_in    = bda_pkg::rom_alpha(idx_ff - 1'b1);
                  yb_in    = bda_pkg::rom_alpha(idx_ff);
                  state_in = bda_pkg::S_MUL_LIN;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         bda_pkg::S_MUL_LIN: begin
            // Linear term: 2*|dy|*(x - xa) / dx.
            mul_a           = {{(bda_pkg::BPL_W-bda_pkg::ALPHA_W){1'b0}}, dy_mag};
            mul_b           = t_off;
            div_req.start   = 1'b1;
            div_req.divisor = dx;
            state_in        = bda_pkg::S_DIV_LIN;
         end

         bda_pkg::S_DIV_LIN: begin
            if (div_rsp.done) begin
               linh_in = dy_neg ? -$signed(half_mag) : $signed(half_mag);
               if (dy_zero) begin
                  corr_in  = '0;
                  state_in = bda_pkg::S_SUM;
               end else begin
                  // Quadratic product 2*(x - xa)*(xb - x), divided by |dy|.
                  mul_a           = t_off;
                  mul_b           = s_off;
                  div_req.start   = 1'b1;
                  div_req.divisor = {{(bda_pkg::DSR_W-bda_pkg::ALPHA_W){1'b0}}, dy_mag};
                  state_in        = bda_pkg::S_DIV_Q1;
               end
            end
         end

         bda_pkg::S_DIV_Q1: begin
            if (div_rsp.done) begin
               div_req.start    = 1'b1;
               div_req.dividend = div_rsp.quotient;
               div_req.divisor  = dx;
               state_in         = bda_pkg::S_DIV_CORR;
            end
         end

         bda_pkg::S_DIV_CORR: begin
            if (div_rsp.done) begin
               // The first division leaves the sign opposite to dy; dividing by xa - xb
               // (negative) flips it back, so the correction carries the sign of dy.
               corr_in = dy_neg
                       ? -$signed({1'b0, div_rsp.quotient[bda_pkg::CORR_W-2:0]})
                       :  $signed({1'b0, div_rsp.quotient[bda_pkg::CORR_W-2:0]});
               state_in = bda_pkg::S_SUM;
            end
         end

         bda_pkg::S_SUM: begin
            if (sum < 0) begin
               result_in = '0;
            end else if (sum > bda_pkg::SUM_W'(255)) begin
               result_in = '1;
            end else begin
               result_in = sum[bda_pkg::ALPHA_W-1:0];
            end
            saved_in = result_in;
            state_in = bda_pkg::S_DONE;
         end

         bda_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_alpha_in = result_ff;
               state_in     = bda_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = bda_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bda_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         override_ff  <= '0;
         saved_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         override_ff  <= override_in;
         saved_ff     <= saved_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_alpha_ff <= rsp_alpha_in;
      level_ff     <= level_in;
      idx_ff       <= idx_in;
      xa_ff        <= xa_in;
      xb_ff        <= xb_in;
      ya_ff        <= ya_in;
      yb_ff        <= yb_in;
      linh_ff      <= linh_in;
      corr_ff      <= corr_in;
      result_ff    <= result_in;
   end

   // The saved alpha only moves when an interpolation or a clamp finishes.
   a_saved_source: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(saved_ff)) |->
         ($past(state_ff) == bda_pkg::S_SUM || $past(state_ff) == bda_pkg::S_SCAN))
      else $error("saved alpha changed outside of a computation");

   // Divider completions are only ever seen while the sequencer waits for one.
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |->
         (state_ff == bda_pkg::S_DIV_LIN || state_ff == bda_pkg::S_DIV_Q1 ||
          state_ff == bda_pkg::S_DIV_CORR))
      else $error("divider result arrived outside a wait state");

   // Leaving the finish state always hands a result to the output register.
   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bda_pkg::S_DONE && state_in == bda_pkg::S_IDLE) |=> rsp_valid_ff)
      else $error("result lost when returning to idle");

endmodule

### hdl/bda_div.sv
// Iterative restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on bda_pkg for widths and the request/response structs.
module bda_div (
   input  logic                 clock,
   input  logic                 reset,
   input  bda_pkg::div_req_type div_req,
   output bda_pkg::div_rsp_type div_rsp
);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [bda_pkg::DCNT_W-1:0]   cnt_ff, cnt_in;
   logic [bda_pkg::DSR_W-1:0]    rem_ff, rem_in;
   logic [bda_pkg::DIVD_W-1:0]   quo_ff, quo_in;
   logic [bda_pkg::DSR_W-1:0]    dsr_ff, dsr_in;

   logic [bda_pkg::DSR_W:0]      shifted;
   logic [bda_pkg::DSR_W:0]      diff;
   logic                         fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[bda_pkg::DIVD_W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      fits    = (shifted >= {1'b0, dsr_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;

      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so it fits DSR_W bits.
         rem_in = fits ? diff[bda_pkg::DSR_W-1:0] : shifted[bda_pkg::DSR_W-1:0];
         quo_in = {quo_ff[bda_pkg::DIVD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == bda_pkg::DCNT_W'(bda_pkg::DIVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   // A new division is only launched while the unit is free.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider started while busy");

   // A launch makes the unit busy on the next cycle.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> busy_ff)
      else $error("divider did not go busy after start");

   // Completion is a single-cycle pulse and never overlaps busy.
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (!busy_ff && !$past(done_ff)))
      else $error("divider done is not a clean pulse");

endmodule
